// ----- rtl/core/rbb_pkg.sv -----
// Shared constants for the RGB box blur block.
`default_nettype none

package rbb_pkg;

    localparam int PIX_W      = 8;
    localparam int RGB_W      = 3 * PIX_W;
    localparam int FILTER_W   = 3;
    localparam int IWIDTH_W   = 11;
    localparam int IHEIGHT_W  = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int MAX_HEIGHT = 4096;
    localparam int HGT_W      = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/core/rbb_line_mem.sv -----
// Line store: single-port-write, single-port-read memory with registered read data.
`default_nettype none

module rbb_line_mem #(
    parameter int DEPTH = 6151,
    parameter int AW    = 13
) (
    input  wire logic                    clk,
    input  wire logic                    wr_en,
    input  wire logic [AW-1:0]           wr_addr,
    input  wire logic [rbb_pkg::RGB_W-1:0] wr_data,
    input  wire logic                    rd_en,
    input  wire logic [AW-1:0]           rd_addr,
    output logic      [rbb_pkg::RGB_W-1:0] rd_data
);
    import rbb_pkg::*;

    logic [RGB_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/rbb_divider.sv -----
// Three-lane restoring divider sharing one divisor and one step counter.
`default_nettype none

module rbb_divider #(
    parameter int SW  = 14,
    parameter int DVW = 6
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [SW-1:0]             dividend_r,
    input  wire logic [SW-1:0]             dividend_g,
    input  wire logic [SW-1:0]             dividend_b,
    input  wire logic [DVW-1:0]            divisor,
    output logic                           done,
    output logic      [rbb_pkg::PIX_W-1:0] quot_r,
    output logic      [rbb_pkg::PIX_W-1:0] quot_g,
    output logic      [rbb_pkg::PIX_W-1:0] quot_b
);
    import rbb_pkg::*;

    localparam int CW = $clog2(SW + 1);

    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           done_reg, done_next;
    logic [SW-1:0]  quo_reg  [3];
    logic [SW-1:0]  quo_next [3];
    logic [DVW-1:0] rem_reg  [3];
    logic [DVW-1:0] rem_next [3];
    logic [DVW:0]   trial    [3];
    logic [SW-1:0]  dvd      [3];

    assign dvd[0] = dividend_r;
    assign dvd[1] = dividend_g;
    assign dvd[2] = dividend_b;

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            quo_next[i] = quo_reg[i];
            rem_next[i] = rem_reg[i];
            trial[i]    = {rem_reg[i], quo_reg[i][SW-1]};
        end
        if (start)
        begin
            cnt_next = CW'(SW);
            for (int i = 0; i < 3; i++)
            begin
                quo_next[i] = dvd[i];
                rem_next[i] = '0;
            end
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                done_next = 1'b1;
            end
            for (int i = 0; i < 3; i++)
            begin
                if (trial[i] >= {1'b0, divisor})
                begin
                    rem_next[i] = DVW'(trial[i] - {1'b0, divisor});
                    quo_next[i] = {quo_reg[i][SW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = trial[i][DVW-1:0];
                    quo_next[i] = {quo_reg[i][SW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            quo_reg[i] <= quo_next[i];
            rem_reg[i] <= rem_next[i];
        end
    end

    assign done   = done_reg;
    assign quot_r = quo_reg[0][PIX_W-1:0];
    assign quot_g = quo_reg[1][PIX_W-1:0];
    assign quot_b = quo_reg[2][PIX_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/rgb_box_blur_zero_pad_top.sv -----
// Box blur over an RGB raster stream with zero padding, built around a line store.
// Channels: in (func, red_in, green_in, blue_in), out (red_mean, green_mean,
// blue_mean, frame_last), cfg (cfg_index, cfg_data); each uses valid/ready.
// Pixels arrive in raster order; flush items after the frame push out the tail.
// Result k is produced on input item k + r*W + r, r = (f+1)/2 - 1, f the filter side.
// Items that produce no result leave the block idle. An item that produces a result
// starts a scan: the window is read from the line store one entry per cycle, then
// a shared bit-serial divider runs SW steps (SW = 14 for MAX_FILTER = 7). The
// single read port of the line store sets the scan length.
// The output register lets the next item enter while a result waits; a new
// result waits in the block until the receiver takes the previous one.
// Reset loads filter side 3, width 640, height 480 and clears both positions.
// After reset or any config write the input stays stalled while the frame
// geometry is recomputed. A config write to filter, width or height also drops
// the frame in progress. The line store is not cleared; only pixels of the
// current frame are ever read back.
`default_nettype none

module rgb_box_blur_zero_pad_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_FILTER = 7
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            func,
    input  wire logic [rbb_pkg::PIX_W-1:0]       red_in,
    input  wire logic [rbb_pkg::PIX_W-1:0]       green_in,
    input  wire logic [rbb_pkg::PIX_W-1:0]       blue_in,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [rbb_pkg::PIX_W-1:0]       red_mean,
    output logic      [rbb_pkg::PIX_W-1:0]       green_mean,
    output logic      [rbb_pkg::PIX_W-1:0]       blue_mean,
    output logic                                 frame_last,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rbb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rbb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rbb_pkg::*;

    localparam int STORE_DEPTH = MAX_WIDTH * (MAX_FILTER - 1) + MAX_FILTER;
    localparam int AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int FW  = $clog2(MAX_FILTER + 1);
    localparam int PW  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH * MAX_FILTER + 1);
    localparam int SW  = $clog2(MAX_FILTER * MAX_FILTER * 255 + 1);
    localparam int DVW = 2 * FW;
    localparam int PREP_CYCLES = 4;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_DIV   = 5'b01000,
        S_HOLD  = 5'b10000
    } state_t;

    // configuration
    logic [FILTER_W-1:0]  cfg_filter_reg;
    logic [IWIDTH_W-1:0]  cfg_width_reg;
    logic [IHEIGHT_W-1:0] cfg_height_reg;
    logic                 cfg_xfer;
    logic                 cfg_hit;

    // derived geometry
    int                   f_int, w_int, h_int;
    logic [FW-1:0]        f_reg, r_reg;
    logic [WW-1:0]        w_reg;
    logic [HGT_W-1:0]     h_reg;
    logic [PW-1:0]        total_reg, rw_reg, lead_reg;
    logic [AW-1:0]        span_reg;
    logic [DVW-1:0]       div_reg;
    logic [2:0]           prep_reg;

    // control
    state_t               state_reg, state_next;
    logic [PW-1:0]        in_pos_reg, out_pos_reg;
    logic [AW-1:0]        ptr_reg;
    logic [WW-1:0]        out_x_reg;
    logic [HGT_W-1:0]     out_y_reg;
    logic                 in_xfer, out_xfer, pix_ok, ignore, has_result, commit;
    logic [AW-1:0]        ptr_inc;
    logic [AW:0]          base_sum;
    logic [AW-1:0]        base;

    // window scan
    logic [FW-1:0]        dx_reg, dy_reg, two_r;
    logic signed [WW+1:0]   xx_reg, xx0_reg;
    logic signed [HGT_W:0]  yy_reg;
    logic [AW-1:0]        row_addr_reg, col_addr_reg;
    logic [AW:0]          row_sum;
    logic [AW-1:0]        row_wrap, col_wrap;
    logic                 in_bounds, rd_en, tag_reg, scan_end;
    logic [RGB_W-1:0]     rd_data;
    logic [SW-1:0]        sum_r_reg, sum_g_reg, sum_b_reg;
    logic                 start_reg;

    // divider
    logic                 div_done;
    logic [PIX_W-1:0]     q_r, q_g, q_b;

    // output
    logic                 out_valid_reg;
    logic [PIX_W-1:0]     red_reg, green_reg, blue_reg;
    logic                 last_reg;
    logic                 is_last;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_xfer && (cfg_index == CFG_FILTER || cfg_index == CFG_WIDTH ||
                                    cfg_index == CFG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_filter_reg <= FILTER_W'(3);
            cfg_width_reg  <= IWIDTH_W'(640);
            cfg_height_reg <= IHEIGHT_W'(480);
        end
        else if (cfg_xfer)
        begin
            unique case (cfg_index)
                CFG_FILTER: cfg_filter_reg <= cfg_data[FILTER_W-1:0];
                CFG_WIDTH:  cfg_width_reg  <= cfg_data[IWIDTH_W-1:0];
                CFG_HEIGHT: cfg_height_reg <= cfg_data[IHEIGHT_W-1:0];
                default:    ;
            endcase
        end
    end

    // clamp the registers to their working ranges
    always_comb
    begin
        f_int = int'(cfg_filter_reg);
        if (f_int < 1) f_int = 1;
        if (f_int > MAX_FILTER) f_int = MAX_FILTER;
        w_int = int'(cfg_width_reg);
        if (w_int < 1) w_int = 1;
        if (w_int > MAX_WIDTH) w_int = MAX_WIDTH;
        h_int = int'(cfg_height_reg);
        if (h_int < 1) h_int = 1;
        if (h_int > MAX_HEIGHT) h_int = MAX_HEIGHT;
    end

    always_ff @(posedge clk)
    begin
        f_reg     <= FW'(f_int);
        r_reg     <= FW'((f_int + 1) / 2 - 1);
        w_reg     <= WW'(w_int);
        h_reg     <= HGT_W'(h_int);
        total_reg <= PW'(w_reg * h_reg);
        rw_reg    <= PW'(r_reg * w_reg);
        div_reg   <= DVW'(f_reg * f_reg);
        lead_reg  <= rw_reg + PW'(r_reg);
        span_reg  <= AW'({lead_reg, 1'b0});
    end

    // hold input off until the geometry pipeline has settled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_reg <= '0;
        end
        else if (cfg_xfer)
        begin
            prep_reg <= '0;
        end
        else if (prep_reg != 3'(PREP_CYCLES))
        begin
            prep_reg <= prep_reg + 1'b1;
        end
    end

    assign in_ready   = (state_reg == S_IDLE) && (prep_reg == 3'(PREP_CYCLES));
    assign in_xfer    = in_valid && in_ready;
    assign out_xfer   = out_valid_reg && out_ready;
    assign pix_ok     = in_pos_reg < total_reg;
    assign ignore     = (func == FUNC_FLUSH) && pix_ok;
    assign has_result = in_pos_reg >= lead_reg;
    assign ptr_inc    = (ptr_reg == AW'(STORE_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;

    assign base_sum = (ptr_reg >= span_reg) ? {1'b0, ptr_reg - span_reg}
                                            : {1'b0, ptr_reg} + (AW+1)'(STORE_DEPTH)
                                              - {1'b0, span_reg};
    assign base     = base_sum[AW-1:0];

    assign two_r    = FW'({r_reg, 1'b0});
    assign scan_end = (dx_reg == two_r) && (dy_reg == two_r);
    assign in_bounds = (xx_reg >= 0) && (xx_reg < $signed({2'b00, w_reg})) &&
                       (yy_reg >= 0) && (yy_reg < $signed({1'b0, h_reg}));
    assign rd_en    = (state_reg == S_SCAN) && in_bounds;
    assign col_wrap = (col_addr_reg == AW'(STORE_DEPTH - 1)) ? '0 : col_addr_reg + 1'b1;
    assign row_sum  = {1'b0, row_addr_reg} + (AW+1)'(w_reg);
    assign row_wrap = (row_sum >= (AW+1)'(STORE_DEPTH)) ?
                      AW'(row_sum - (AW+1)'(STORE_DEPTH)) : row_sum[AW-1:0];

    assign is_last = (out_pos_reg == total_reg - 1'b1);
    assign commit  = (!out_valid_reg || out_ready) &&
                     (((state_reg == S_DIV) && div_done) || (state_reg == S_HOLD));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && !ignore && has_result)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = commit ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            in_pos_reg  <= '0;
            out_pos_reg <= '0;
            ptr_reg     <= '0;
            out_x_reg   <= '0;
            out_y_reg   <= '0;
            tag_reg     <= 1'b0;
            start_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tag_reg   <= rd_en;
            start_reg <= (state_reg == S_DRAIN);
            if (cfg_hit)
            begin
                state_reg   <= S_IDLE;
                in_pos_reg  <= '0;
                out_pos_reg <= '0;
                ptr_reg     <= '0;
                out_x_reg   <= '0;
                out_y_reg   <= '0;
            end
            else if (in_xfer && !ignore)
            begin
                in_pos_reg <= in_pos_reg + 1'b1;
                ptr_reg    <= ptr_inc;
            end
            else if (commit)
            begin
                if (is_last)
                begin
                    in_pos_reg  <= '0;
                    out_pos_reg <= '0;
                    ptr_reg     <= '0;
                    out_x_reg   <= '0;
                    out_y_reg   <= '0;
                end
                else
                begin
                    out_pos_reg <= out_pos_reg + 1'b1;
                    if (out_x_reg == w_reg - 1'b1)
                    begin
                        out_x_reg <= '0;
                        out_y_reg <= out_y_reg + 1'b1;
                    end
                    else
                    begin
                        out_x_reg <= out_x_reg + 1'b1;
                    end
                end
            end
        end
    end

    // window walk: column inner, row outer
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            dx_reg       <= '0;
            dy_reg       <= '0;
            xx_reg       <= $signed({2'b00, out_x_reg}) - $signed((WW+2)'(r_reg));
            xx0_reg      <= $signed({2'b00, out_x_reg}) - $signed((WW+2)'(r_reg));
            yy_reg       <= $signed({1'b0, out_y_reg}) - $signed((HGT_W+1)'(r_reg));
            row_addr_reg <= base;
            col_addr_reg <= base;
            sum_r_reg    <= '0;
            sum_g_reg    <= '0;
            sum_b_reg    <= '0;
        end
        else
        begin
            if (state_reg == S_SCAN && !scan_end)
            begin
                if (dx_reg == two_r)
                begin
                    dx_reg       <= '0;
                    dy_reg       <= dy_reg + 1'b1;
                    xx_reg       <= xx0_reg;
                    yy_reg       <= yy_reg + 1'b1;
                    row_addr_reg <= row_wrap;
                    col_addr_reg <= row_wrap;
                end
                else
                begin
                    dx_reg       <= dx_reg + 1'b1;
                    xx_reg       <= xx_reg + 1'b1;
                    col_addr_reg <= col_wrap;
                end
            end
            if (tag_reg)
            begin
                sum_r_reg <= sum_r_reg + SW'(rd_data[RGB_W-1 -: PIX_W]);
                sum_g_reg <= sum_g_reg + SW'(rd_data[PIX_W +: PIX_W]);
                sum_b_reg <= sum_b_reg + SW'(rd_data[PIX_W-1:0]);
            end
        end
    end

    rbb_line_mem #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (in_xfer && (func == FUNC_PIXEL) && pix_ok),
        .wr_addr (ptr_reg),
        .wr_data ({red_in, green_in, blue_in}),
        .rd_en   (rd_en),
        .rd_addr (col_addr_reg),
        .rd_data (rd_data)
    );

    rbb_divider #(
        .SW  (SW),
        .DVW (DVW)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start_reg),
        .dividend_r (sum_r_reg),
        .dividend_g (sum_g_reg),
        .dividend_b (sum_b_reg),
        .divisor    (div_reg),
        .done       (div_done),
        .quot_r     (q_r),
        .quot_g     (q_g),
        .quot_b     (q_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            red_reg   <= q_r;
            green_reg <= q_g;
            blue_reg  <= q_b;
            last_reg  <= is_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_mean   = red_reg;
    assign green_mean = green_reg;
    assign blue_mean  = blue_reg;
    assign frame_last = last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/rbb_checker.sv -----
// Port-level checks for the box blur top level, bound to it.
`default_nettype none

module rbb_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [rbb_pkg::PIX_W-1:0]  red_mean,
    input wire logic [rbb_pkg::PIX_W-1:0]  green_mean,
    input wire logic [rbb_pkg::PIX_W-1:0]  blue_mean,
    input wire logic                       frame_last,
    input wire logic                       cfg_valid,
    input wire logic                       cfg_ready
);
    import rbb_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({red_mean, green_mean, blue_mean, frame_last}))
        else $error("result changed while stalled");

    a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !in_ready)
        else $error("input taken right after config transfer");

    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while input was open");

endmodule

bind rgb_box_blur_zero_pad_top rbb_checker u_rbb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red_mean   (red_mean),
    .green_mean (green_mean),
    .blue_mean  (blue_mean),
    .frame_last (frame_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
);

`default_nettype wire

// ----- test/tb_rgb_box_blur_zero_pad_top.sv -----
// Testbench for the RGB box blur: directed table, saturating geometry, then random frames checked by a predictor.
`timescale 1ns / 100ps

module tb_rgb_box_blur_zero_pad_top;
    import rbb_pkg::*;

    localparam int MAX_WID     = 1024;
    localparam int MAX_FLT     = 7;
    localparam int STORE_DEPTH = MAX_WID * (MAX_FLT - 1) + MAX_FLT;
    localparam int SETTLE      = 120;
    localparam int CUT_MAX     = 160;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } blur_px_t;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;
    typedef enum logic [1:0] {EXP_ANY, EXP_NONE, EXP_ONE} row_exp_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  fn;
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
        row_exp_t              ek;
        blur_px_t              exp_px;
    } stim_row_t;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic func = 1'b0;
    logic [7:0] red_in = '0;
    logic [7:0] green_in = '0;
    logic [7:0] blue_in = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [7:0] red_mean;
    logic [7:0] green_mean;
    logic [7:0] blue_mean;
    logic frame_last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor state
    logic [23:0] line_mem [STORE_DEPTH];
    int unsigned in_pos = 0;
    int unsigned out_pos = 0;
    int unsigned flt_eff = 3;
    int unsigned w_eff = 640;
    int unsigned h_eff = 480;

    blur_px_t   pending_px [$];
    int         err_count = 0;
    idle_mode_t idle_mode = IDLE_NONE;
    int         random_items = 0;

    rgb_box_blur_zero_pad_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red_mean   (red_mean),
        .green_mean (green_mean),
        .blue_mean  (blue_mean),
        .frame_last (frame_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string what, input int expv, input int gotv);
        begin
            $display("MISMATCH %s: expected %0d, got %0d at %0t", what, expv, gotv, $realtime);
            err_count++;
        end
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        int unsigned v;
        begin
            if (idx == CFG_FILTER) begin
                v = 32'(val & 13'h7);
                flt_eff = (v < 1) ? 1 : (v > MAX_FLT ? MAX_FLT : v);
            end else if (idx == CFG_WIDTH) begin
                v = 32'(val & 13'h7FF);
                w_eff = (v < 1) ? 1 : (v > MAX_WID ? MAX_WID : v);
            end else if (idx == CFG_HEIGHT) begin
                v = 32'(val);
                h_eff = (v < 1) ? 1 : (v > MAX_HEIGHT ? MAX_HEIGHT : v);
            end
            in_pos  = 0;
            out_pos = 0;
        end
    endtask

    // Window mean for the next output pixel; returns got = 0 when no result is due.
    task automatic predict_blur(input logic fn, input logic [7:0] rv, input logic [7:0] gv,
                                input logic [7:0] bv, output bit got, output blur_px_t res);
        int unsigned rad, tot, lead, n, k, y, x, sr, sg, sb, dv, p;
        int yy, xx;
        logic [23:0] e;
        begin
            got = 0;
            res = '0;
            rad = (flt_eff + 1) / 2 - 1;
            tot = w_eff * h_eff;
            lead = rad * w_eff + rad;
            if (fn == FUNC_FLUSH && in_pos < tot) return;
            if (fn == FUNC_PIXEL && in_pos < tot) line_mem[in_pos % STORE_DEPTH] = {rv, gv, bv};
            n = in_pos;
            in_pos++;
            if (n < lead) return;
            k = out_pos;
            y = k / w_eff;
            x = k % w_eff;
            sr = 0;
            sg = 0;
            sb = 0;
            for (int dy = 0; dy <= 2 * rad; dy++) begin
                yy = int'(y) + dy - int'(rad);
                if (yy < 0 || yy >= int'(h_eff)) continue;
                for (int dx = 0; dx <= 2 * rad; dx++) begin
                    xx = int'(x) + dx - int'(rad);
                    if (xx < 0 || xx >= int'(w_eff)) continue;
                    p = yy * w_eff + xx;
                    e = line_mem[p % STORE_DEPTH];
                    sr += 32'(e[23:16]);
                    sg += 32'(e[15:8]);
                    sb += 32'(e[7:0]);
                end
            end
            dv = flt_eff * flt_eff;
            res.red   = 8'(sr / dv);
            res.green = 8'(sg / dv);
            res.blue  = 8'(sb / dv);
            res.last  = (k + 1 == tot);
            got = 1;
            out_pos++;
            if (res.last) begin
                in_pos  = 0;
                out_pos = 0;
            end
        end
    endtask

    // Called at a falling edge; returns at a falling edge after the transfer.
    task automatic send_item(input logic fn, input logic [7:0] rv, input logic [7:0] gv,
                             input logic [7:0] bv, output bit got, output blur_px_t res);
        begin
            if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) begin
                while ($urandom_range(99) < (idle_mode == IDLE_SEND ? 71 : 19)) begin
                    in_valid <= 1'b0;
                    @(negedge clk);
                end
            end
            in_valid <= 1'b1;
            func     <= fn;
            red_in   <= rv;
            green_in <= gv;
            blue_in  <= bv;
            do @(posedge clk); while (!in_ready);
            predict_blur(fn, rv, gv, bv, got, res);
            if (got) pending_px.push_back(res);
            @(negedge clk);
        end
    endtask

    task automatic wait_drain;
        begin
            while (pending_px.size() != 0) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        begin
            in_valid <= 1'b0;
            wait_drain();
            repeat (SETTLE) @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            do @(posedge clk); while (!cfg_ready);
            apply_reg(idx, val);
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    // Receiver stalls
    always @(negedge clk) begin
        case (idle_mode)
            IDLE_RECV: out_ready <= ($urandom_range(99) >= 71);
            IDLE_BOTH: out_ready <= ($urandom_range(99) >= 19);
            default:   out_ready <= 1'b1;
        endcase
    end

    always @(posedge clk) begin
        blur_px_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_px.size() == 0) begin
                report_mismatch("unexpected result", 0, 1);
            end else begin
                want = pending_px.pop_front();
                if (red_mean !== want.red)
                    report_mismatch("red_mean", int'(want.red), int'(red_mean));
                if (green_mean !== want.green)
                    report_mismatch("green_mean", int'(want.green), int'(green_mean));
                if (blue_mean !== want.blue)
                    report_mismatch("blue_mean", int'(want.blue), int'(blue_mean));
                if (frame_last !== want.last)
                    report_mismatch("frame_last", int'(want.last), int'(frame_last));
            end
        end
    end

    task automatic run_frames(input int unsigned f, input int unsigned w, input int unsigned h,
                              input int n_frames, input bit cut_short, input bit hold_mid);
        int unsigned rad, tot, lead, stop_at;
        int content;
        bit got;
        blur_px_t res;
        logic [7:0] rv, gv, bv;
        begin
            write_reg(CFG_FILTER, CFG_DATA_W'(f));
            write_reg(CFG_WIDTH, CFG_DATA_W'(w));
            write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
            rad = (flt_eff + 1) / 2 - 1;
            tot = w_eff * h_eff;
            lead = rad * w_eff + rad;
            for (int fr = 0; fr < n_frames + (cut_short ? 1 : 0); fr++) begin
                content = $urandom_range(5);
                // cut the last frame somewhere short of its end
                stop_at = (fr == n_frames) ?
                          $urandom_range((tot + lead > CUT_MAX) ? CUT_MAX - 1 : tot + lead - 1) :
                          tot + lead;
                for (int unsigned pos = 0; pos < stop_at; pos++) begin
                    if (hold_mid && fr == 0 && pos == tot / 2) begin
                        in_valid <= 1'b0;
                        wait_drain();
                    end
                    // noise: flush before the frame is complete
                    if (pos < tot && $urandom_range(99) < 8)
                        send_item(FUNC_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom), got, res);
                    case (content)
                        0: begin rv = 8'hFF; gv = 8'hFF; bv = 8'hFF; end
                        1: begin
                            rv = {8{1'($urandom_range(1))}};
                            gv = {8{1'($urandom_range(1))}};
                            bv = {8{1'($urandom_range(1))}};
                        end
                        default: begin rv = 8'($urandom); gv = 8'($urandom); bv = 8'($urandom); end
                    endcase
                    if (pos < tot || $urandom_range(99) < 30)
                        send_item(FUNC_PIXEL, rv, gv, bv, got, res);
                    else
                        send_item(FUNC_FLUSH, rv, gv, bv, got, res);
                    random_items++;
                end
            end
        end
    endtask

    initial begin
        stim_row_t rows [];
        bit got;
        blur_px_t res;
        int phase;

        rows = '{
            '{ROW_CFG,  CFG_FILTER, 13'd1, FUNC_PIXEL, 8'd0,   8'd0,   8'd0,   EXP_ANY,  '0},
            '{ROW_CFG,  CFG_WIDTH,  13'd2, FUNC_PIXEL, 8'd0,   8'd0,   8'd0,   EXP_ANY,  '0},
            '{ROW_CFG,  CFG_HEIGHT, 13'd2, FUNC_PIXEL, 8'd0,   8'd0,   8'd0,   EXP_ANY,  '0},
            '{ROW_ITEM, CFG_FILTER, 13'd0, FUNC_PIXEL, 8'd0,   8'd0,   8'd0,   EXP_ONE,
              '{8'd0, 8'd0, 8'd0, 1'b0}},
            '{ROW_ITEM, CFG_FILTER, 13'd0, FUNC_FLUSH, 8'd255, 8'd255, 8'd255, EXP_NONE, '0},
            '{ROW_ITEM, CFG_FILTER, 13'd0, FUNC_PIXEL, 8'd255, 8'd255, 8'd255, EXP_ONE,
              '{8'd255, 8'd255, 8'd255, 1'b0}},
            '{ROW_ITEM, CFG_FILTER, 13'd0, FUNC_PIXEL, 8'd1,   8'd2,   8'd3,   EXP_ONE,
              '{8'd1, 8'd2, 8'd3, 1'b0}},
            '{ROW_ITEM, CFG_FILTER, 13'd0, FUNC_PIXEL, 8'd128, 8'd64,  8'd32,  EXP_ONE,
              '{8'd128, 8'd64, 8'd32, 1'b1}},
            '{ROW_CFG,  CFG_FILTER, 13'd2, FUNC_PIXEL, 8'd0,   8'd0,   8'd0,   EXP_ANY,  '0},
            '{ROW_ITEM, CFG_FILTER, 13'd0, FUNC_PIXEL, 8'd255, 8'd128, 8'd4,   EXP_ONE,
              '{8'd63, 8'd32, 8'd1, 1'b0}},
            '{ROW_CFG,  CFG_FILTER, 13'd0, FUNC_PIXEL, 8'd0,   8'd0,   8'd0,   EXP_ANY,  '0},
            '{ROW_ITEM, CFG_FILTER, 13'd0, FUNC_PIXEL, 8'd200, 8'd100, 8'd50,  EXP_ONE,
              '{8'd200, 8'd100, 8'd50, 1'b0}},
            '{ROW_CFG,  CFG_FILTER, 13'd7, FUNC_PIXEL, 8'd0,   8'd0,   8'd0,   EXP_ANY,  '0},
            '{ROW_CFG,  CFG_WIDTH,  13'd0, FUNC_PIXEL, 8'd0,   8'd0,   8'd0,   EXP_ANY,  '0},
            '{ROW_CFG,  CFG_HEIGHT, 13'd0, FUNC_PIXEL, 8'd0,   8'd0,   8'd0,   EXP_ANY,  '0},
            '{ROW_ITEM, CFG_FILTER, 13'd0, FUNC_PIXEL, 8'd255, 8'd255, 8'd255, EXP_NONE, '0},
            '{ROW_ITEM, CFG_FILTER, 13'd0, FUNC_PIXEL, 8'd10,  8'd20,  8'd30,  EXP_NONE, '0},
            '{ROW_ITEM, CFG_FILTER, 13'd0, FUNC_FLUSH, 8'd0,   8'd0,   8'd0,   EXP_NONE, '0},
            '{ROW_ITEM, CFG_FILTER, 13'd0, FUNC_FLUSH, 8'd0,   8'd0,   8'd0,   EXP_NONE, '0},
            '{ROW_ITEM, CFG_FILTER, 13'd0, FUNC_FLUSH, 8'd0,   8'd0,   8'd0,   EXP_NONE, '0},
            '{ROW_ITEM, CFG_FILTER, 13'd0, FUNC_FLUSH, 8'd0,   8'd0,   8'd0,   EXP_NONE, '0},
            '{ROW_ITEM, CFG_FILTER, 13'd0, FUNC_FLUSH, 8'd0,   8'd0,   8'd0,   EXP_ONE,
              '{8'd5, 8'd5, 8'd5, 1'b1}}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                write_reg(rows[i].idx, rows[i].data);
            end else begin
                send_item(rows[i].fn, rows[i].red, rows[i].green, rows[i].blue, got, res);
                if (rows[i].ek == EXP_NONE && got) report_mismatch("directed result count", 0, 1);
                if (rows[i].ek == EXP_ONE) begin
                    if (!got) report_mismatch("directed result count", 1, 0);
                    else if (res !== rows[i].exp_px)
                        report_mismatch("directed predicted pixel", int'(rows[i].exp_px),
                                        int'(res));
                end
            end
        end

        // Saturating geometry: widest row and tallest column, each cut short.
        run_frames(7, 2047, 1, 0, 1'b1, 1'b0);
        run_frames(1, 1, 8191, 0, 1'b1, 1'b0);

        phase = 0;
        while (random_items < 1250) begin
            idle_mode = idle_mode_t'(phase % 4);
            run_frames($urandom_range(7), $urandom_range(1, 12), $urandom_range(1, 6),
                       $urandom_range(1, 3), $urandom_range(99) < 30, phase == 3);
            phase++;
        end

        in_valid <= 1'b0;
        wait_drain();
        repeat (SETTLE) @(negedge clk);
        if (err_count == 0)
            $display("tb_rgb_box_blur_zero_pad_top: done, clean");
        else
            $display("tb_rgb_box_blur_zero_pad_top: done, errors");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("tb_rgb_box_blur_zero_pad_top: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/rbb_pkg.sv
rtl/core/rbb_line_mem.sv
rtl/core/rbb_divider.sv
rtl/core/rgb_box_blur_zero_pad_top.sv
rtl/core/rbb_checker.sv
test/tb_rgb_box_blur_zero_pad_top.sv
